[sv/tick_wrap_extend_to_timespec_unit_defines.svh]
// assertion macros used by the asserting top-level unit
`ifndef TICK_WRAP_EXTEND_TO_TIMESPEC_UNIT_DEFINES_SVH
`define TICK_WRAP_EXTEND_TO_TIMESPEC_UNIT_DEFINES_SVH

// same-cycle implication
`define TWTE_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWTE_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

[sv/twte_pkg.sv]
`default_nettype none
package twte_pkg;
  localparam int SAMPLE_W = 32;
  localparam int RATE_W   = 20;
  localparam int SEC_W    = 64;
  localparam int NS_W     = 30;
  localparam int PROD_W   = RATE_W + NS_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [NS_W-1:0]     NS_PER_SEC   = NS_W'(1000000000);
  localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(1000);
  localparam logic [ADDR_W-1:0]   REG_TICK_RATE = '0;

  // one job handed from the front to the divider
  typedef struct packed {
    logic [SEC_W-1:0]  total;
    logic [RATE_W-1:0] rate;
    logic              invalid;
  } twte_job_t;
endpackage
`default_nettype wire

[sv/twte_if.sv]
`default_nettype none
interface twte_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_sample;
  modport source (output valid, output tick_sample, input ready);
  modport sink (input valid, input tick_sample, output ready);
endinterface

interface twte_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] seconds;
  logic [29:0] nanoseconds;
  logic        status;
  modport source (output valid, output seconds, output nanoseconds, output status,
                  input ready);
  modport sink (input valid, input seconds, input nanoseconds, input status,
                output ready);
endinterface
`default_nettype wire

[sv/twte_front.sv]
`default_nettype none
module twte_front
  import twte_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic [RATE_W-1:0]   rate,
  output twte_job_t                job
);
  logic                  started_r;
  logic [TICK_WIDTH-1:0] prev_r;
  logic [SEC_W-1:0]      total_r;
  logic [TICK_WIDTH-1:0] now;
  logic [TICK_WIDTH-1:0] delta;
  logic [SEC_W-1:0]      total_nxt;
  logic                  invalid;

  generate
    if (TICK_WIDTH <= SAMPLE_W) begin : g_narrow
      assign now = sample[TICK_WIDTH-1:0];
    end else begin : g_wide
      assign now = TICK_WIDTH'(sample);
    end
  endgenerate

  assign invalid   = (rate == '0);
  assign delta     = now - prev_r;
  assign total_nxt = started_r ? total_r + SEC_W'(delta) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      prev_r    <= '0;
      total_r   <= '0;
    end else if (acc && !invalid) begin
      started_r <= 1'b1;
      prev_r    <= now;
      total_r   <= total_nxt;
    end
  end

  assign job.total   = invalid ? '0 : total_nxt;
  assign job.rate    = rate;
  assign job.invalid = invalid;
endmodule
`default_nettype wire

[sv/twte_fifo.sv]
`default_nettype none
module twte_fifo
  import twte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  twte_job_t push_data,
  input  wire logic pop,
  output twte_job_t pop_data,
  output logic      full,
  output logic      empty
);
  twte_job_t  mem [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[sv/twte_back.sv]
`default_nettype none
module twte_back
  import twte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_avail,
  input  twte_job_t      job,
  output logic           job_take,
  twte_out_if.source     out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        st_r, st_nxt;
  logic [5:0]        cnt_r;
  logic [SEC_W-1:0]  dvd_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] rate_r;
  logic              inv_r;
  logic [SEC_W-1:0]  sec_r;
  logic [RATE_W:0]   trial;
  logic              ge;
  logic [RATE_W-1:0] rem_step;
  logic [PROD_W-1:0] prod;
  logic              out_free;
  logic              out_valid_r;
  logic [SEC_W-1:0]  out_sec_r;
  logic [NS_W-1:0]   out_ns_r;
  logic              out_stat_r;

  // restoring divide step, one quotient bit a cycle
  assign trial    = {rem_r, dvd_r[SEC_W-1]};
  assign ge       = (trial >= {1'b0, rate_r});
  assign rem_step = ge ? RATE_W'(trial - {1'b0, rate_r}) : trial[RATE_W-1:0];
  assign prod     = PROD_W'(rem_r) * PROD_W'(NS_PER_SEC);

  assign out_free = !out_valid_r || out_ch.ready;
  assign job_take = (st_r == ST_IDLE) && job_avail;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (job_avail) st_nxt = job.invalid ? ST_DONE : ST_DIV1;
      ST_DIV1: if (cnt_r == '1) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_DIV2;
      ST_DIV2: if (cnt_r == '1) st_nxt = ST_DONE;
      ST_DONE: if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DIV1 || st_r == ST_DIV2) begin
        cnt_r <= cnt_r + 6'd1;
      end else begin
        cnt_r <= '0;
      end
      if (st_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        dvd_r  <= job.total;
        rem_r  <= '0;
        rate_r <= job.rate;
        inv_r  <= job.invalid;
        sec_r  <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        dvd_r <= {dvd_r[SEC_W-2:0], ge};
        rem_r <= rem_step;
      end
      ST_MUL: begin
        sec_r <= dvd_r;
        dvd_r <= SEC_W'(prod);
        rem_r <= '0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_sec_r  <= inv_r ? '0 : sec_r;
          out_ns_r   <= inv_r ? '0 : dvd_r[NS_W-1:0];
          out_stat_r <= inv_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.seconds     = out_sec_r;
  assign out_ch.nanoseconds = out_ns_r;
  assign out_ch.status      = out_stat_r;
endmodule
`default_nettype wire

[sv/tick_wrap_extend_to_timespec_unit.sv]
// tick counter sample to seconds/nanoseconds uptime
// in_ch carries one word per sample of a free-running wrapping tick counter;
// out_ch returns one word per sample: seconds, nanoseconds, status
// the first sample after reset marks time zero; later samples add the
// wrapped difference to a 64-bit tick total
// tick_rate register (apb, byte address 0) sets ticks per second; zero
// gives status 1 with zero time and leaves the tick state alone
// the front updates the tick state in the accept cycle and queues a job
// (two entries); the back runs two 64-step restoring divides with one
// multiply between, on a single shared divide step
// path from accept to out valid: pop, 64 divide steps, multiply, 64 divide
// steps, done; a rate-zero word goes from pop straight to done
// the back takes no new job until the last word has left its done state
// reset: tick state cleared, rate back to 1000, queue and output empty
// a stalled receiver holds the output register; the back waits in its
// done state, and the front keeps taking words until the queue is full
`default_nettype none
`include "tick_wrap_extend_to_timespec_unit_defines.svh"
module tick_wrap_extend_to_timespec_unit
  import twte_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  twte_in_if.sink                in_ch,
  twte_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);
  logic [RATE_W-1:0] tick_rate_r;
  logic              in_acc;
  twte_job_t         front_job;
  twte_job_t         back_job;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_TICK_RATE[ADDR_W-1:2])
                  ? DATA_W'(tick_rate_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= RATE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_TICK_RATE[ADDR_W-1:2]) begin
      tick_rate_r <= pwdata[RATE_W-1:0];
    end
  end

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  twte_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .sample (in_ch.tick_sample),
    .rate   (tick_rate_r),
    .job    (front_job)
  );

  twte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (front_job),
    .pop       (q_pop),
    .pop_data  (back_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  twte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job       (back_job),
    .job_take  (q_pop),
    .out_ch    (out_ch)
  );

  `TWTE_ASSERT_NOW(a_invalid_zero, out_ch.valid && out_ch.status,
    out_ch.seconds == '0 && out_ch.nanoseconds == '0, "invalid result carries nonzero time")
  `TWTE_ASSERT_NOW(a_ns_range, out_ch.valid, out_ch.nanoseconds < NS_PER_SEC,
    "nanoseconds out of range")
  `TWTE_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "job taken from empty queue")
  `TWTE_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.seconds), "stalled result changed")
endmodule
`default_nettype wire

[dv/tick_wrap_extend_to_timespec_unit_tb.sv]
`default_nettype none
module tick_wrap_extend_to_timespec_unit_tb;
  import twte_pkg::*;

  // uptime word as seen on the result channel
  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanoseconds;
    logic             status;
  } uptime_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // apb config port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  twte_in_if  in_ch ();
  twte_out_if out_ch ();

  tick_wrap_extend_to_timespec_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block's tick bookkeeping
  logic [RATE_W-1:0]   rate_q = RATE_RESET;
  logic                seen_first = 1'b0;
  logic [SAMPLE_W-1:0] last_sample = '0;
  logic [SEC_W-1:0]    tick_total = '0;

  logic [SAMPLE_W-1:0] sample_q[$];   // samples waiting to be sent
  uptime_t             uptime_q[$];   // predicted words not yet returned
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  fail_cnt = 0;
  int                  word_cnt = 0;
  int                  invalid_cnt = 0;
  int                  wrap_cnt = 0;

  // predicted uptime for one accepted sample
  function automatic uptime_t predict_uptime(logic [SAMPLE_W-1:0] smp);
    uptime_t           u;
    logic [SEC_W-1:0]  rem;
    logic [127:0]      scaled;
    u = '0;
    if (rate_q == '0) begin
      // zero rate: report invalid, tick state untouched
      u.status = 1'b1;
      invalid_cnt++;
      return u;
    end
    if (!seen_first) begin
      // first sample marks time zero
      seen_first = 1'b1;
      tick_total = '0;
    end else begin
      if (smp < last_sample) wrap_cnt++;
      tick_total = tick_total + SEC_W'(SAMPLE_W'(smp - last_sample));
    end
    last_sample = smp;
    rem = tick_total % SEC_W'(rate_q);
    u.seconds = tick_total / SEC_W'(rate_q);
    scaled = (128'(rem) * 128'(1000000000)) / 128'(rate_q);
    u.nanoseconds = scaled[NS_W-1:0];
    return u;
  endfunction

  // driver: pops the sample queue, random gaps per send_idle_pct
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.tick_sample <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) uptime_q.push_back(predict_uptime(in_ch.tick_sample));
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.tick_sample <= sample_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare returned words with the oldest prediction
  always @(posedge clk) begin
    uptime_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        word_cnt++;
        if (uptime_q.size() == 0) begin
          $error("unexpected word: seconds %0d", out_ch.seconds);
          fail_cnt++;
        end else begin
          exp_w = uptime_q.pop_front();
          if (out_ch.seconds !== exp_w.seconds) begin
            $error("seconds exp %0d got %0d", exp_w.seconds, out_ch.seconds);
            fail_cnt++;
          end
          if (out_ch.nanoseconds !== exp_w.nanoseconds) begin
            $error("nanoseconds exp %0d got %0d", exp_w.nanoseconds, out_ch.nanoseconds);
            fail_cnt++;
          end
          if (out_ch.status !== exp_w.status) begin
            $error("status exp %0d got %0d", exp_w.status, out_ch.status);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // wait until everything queued has gone through and come back
  task automatic drain_all();
    while (sample_q.size() > 0 || in_ch.valid || uptime_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write: setup then access cycle
  task automatic write_rate(logic [RATE_W-1:0] r);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_TICK_RATE;
    pwdata <= DATA_W'(r);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rate_q = r;
    @(posedge clk);
  endtask

  // random sample stream: mostly small steps, some wraps and big jumps
  task automatic queue_random(int n, ref logic [SAMPLE_W-1:0] cur);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: cur = $urandom();
        1: cur = cur - 32'($urandom_range(50));
        2, 3: cur = cur + $urandom();
        default: cur = cur + 32'($urandom_range(5000));
      endcase
      sample_q.push_back(cur);
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] cur;
    logic [RATE_W-1:0]   rates[6];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero rate before start, then first sample, wrap, extremes
    write_rate('0);
    sample_q.push_back(32'h1234_5678);
    sample_q.push_back(32'hFFFF_FFFF);
    drain_all();
    write_rate(20'd1000);
    sample_q.push_back(32'hFFFF_FFF0);
    sample_q.push_back(32'h0000_0010);
    sample_q.push_back(32'hFFFF_FFFF);
    sample_q.push_back(32'h0000_0000);
    sample_q.push_back(32'h0000_0000);
    sample_q.push_back(32'h5555_5555);
    sample_q.push_back(32'hAAAA_AAAA);
    drain_all();
    write_rate(20'd1);
    sample_q.push_back(32'h7FFF_FFFF);
    sample_q.push_back(32'hFFFF_FFFE);
    drain_all();
    write_rate(20'd1000000);
    sample_q.push_back(32'h0000_0001);
    sample_q.push_back(32'hFFFF_FFFF);
    drain_all();
    write_rate(20'hFFFFF);
    sample_q.push_back(32'h1234_0000);
    sample_q.push_back(32'h0000_0000);
    // hold off until everything has come back
    drain_all();
    write_rate('0);
    sample_q.push_back(32'h0F0F_0F0F);
    drain_all();

    rates = '{20'd3, 20'd1000, 20'd999983, 20'd1000000, 20'hFFFFF, 20'd0};
    cur = 32'hFFFF_0000;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 27 : 0;
      for (int k = 0; k < 6; k++) begin
        write_rate((k == 5) ? 20'($urandom_range(1, 20'hFFFFF)) : rates[(k + ph) % 6]);
        queue_random(46, cur);
        drain_all();
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) @(posedge clk);

    $display("covered %0d words, %0d with zero rate, %0d counter wraps",
             word_cnt, invalid_cnt, wrap_cnt);
    if (fail_cnt == 0 && uptime_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit, well above the slowest legal run
  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
